### rtl/wavhp_pkg.sv
// wavhp_pkg: parse phases, result kinds, error codes and chunk tags of the wav header parser
// depends on nothing; used by wavhp_out_if and by wav_header_parser_core
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_HDR_FMT,
        PH_SKIP_FMT,
        PH_FMT_BODY,
        PH_HDR_DATA,
        PH_SKIP_DATA,
        PH_PAYLOAD,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_ACCEPT  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_IGNORED = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_RIFF_WAVE = 3'd1,
        ERR_NO_FMT    = 3'd2,
        ERR_NOT_PCM   = 3'd3,
        ERR_FMT_SIZE  = 3'd4,
        ERR_NO_DATA   = 3'd5,
        ERR_BITS      = 3'd6,
        ERR_CHANNELS  = 3'd7
    } err_t;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam logic [15:0] PCM_TAG  = 16'h0001;
    localparam logic [31:0] FMT_SIZE = 32'd16;

    localparam logic [4:0] RIFF_LAST_IDX  = 5'd3;
    localparam logic [4:0] WAVE_LAST_IDX  = 5'd11;
    localparam logic [4:0] TAG_BYTES      = 5'd4;
    localparam logic [4:0] HDR_LAST_IDX   = 5'd7;
    localparam logic [4:0] FMT_CH_IDX     = 5'd2;
    localparam logic [4:0] FMT_RATE_IDX   = 5'd4;
    localparam logic [4:0] FMT_RATE_END   = 5'd8;
    localparam logic [4:0] FMT_BITS_IDX   = 5'd14;
    localparam logic [4:0] FMT_LAST_IDX   = 5'd15;

    localparam logic [15:0] BITS_8     = 16'd8;
    localparam logic [15:0] BITS_16    = 16'd16;
    localparam logic [15:0] CHANNELS_1 = 16'd1;
    localparam logic [15:0] CHANNELS_2 = 16'd2;

endpackage

`default_nettype wire

### rtl/wavhp_in_if.sv
// wavhp_in_if: input channel of the wav header parser, one file byte per word
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface wavhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

### rtl/wavhp_out_if.sv
// wavhp_out_if: result channel of the wav header parser, one result per word
// depends on wavhp_pkg for the kind and error code types
`timescale 1ns / 1ps
`default_nettype none

interface wavhp_out_if
    import wavhp_pkg::*;
    ;
    logic        valid;
    logic        ready;
    kind_t       kind;
    err_t        error_code;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [1:0]  channel_count;
    logic [4:0]  sample_bits;
    logic [31:0] sample_rate;
    logic [31:0] data_size;
    logic [31:0] frame_count;

    modport source (
        output valid, output kind, output error_code, output payload_byte,
        output last_payload, output channel_count, output sample_bits,
        output sample_rate, output data_size, output frame_count, input ready
    );
    modport sink (
        input valid, input kind, input error_code, input payload_byte,
        input last_payload, input channel_count, input sample_bits,
        input sample_rate, input data_size, input frame_count, output ready
    );
endinterface

`default_nettype wire

### rtl/wav_header_parser_core.sv
// wav_header_parser_core: byte-serial RIFF/WAVE PCM header parser with payload pass-through
// depends on wavhp_pkg, wavhp_in_if and wavhp_out_if
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of a WAV file per word and returns one result word per byte, in order.
// A byte with restart set clears the parser before it is parsed. The block accepts one
// byte every clock while the result is not stalled: the byte is registered in the input
// register, then the whole parse step (phase, chunk header shifts, fmt checks, payload
// countdown) is combinational logic into the result register, which also updates the
// parser state. A stalled result holds both stages; while the result register is full
// and not taken, one more byte is held in the input register.
module wav_header_parser_core
    import wavhp_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    wavhp_in_if.sink     in_ch,
    wavhp_out_if.source  out_ch
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;

    phase_t      phase_reg,   phase_next;
    logic [4:0]  idx_reg,     idx_next;
    logic [31:0] skip_reg,    skip_next;
    logic [31:0] tag_reg,     tag_next;
    logic [31:0] len_reg,     len_next;
    logic [15:0] fmt_reg,     fmt_next;
    logic [15:0] chans_reg,   chans_next;
    logic [31:0] rate_reg,    rate_next;
    logic [15:0] bits_reg,    bits_next;
    logic [31:0] remain_reg,  remain_next;
    err_t        err_reg,     err_next;

    phase_t      cur_phase;
    logic [4:0]  cur_idx;
    logic [31:0] cur_skip;
    logic [31:0] cur_tag;
    logic [31:0] cur_len;
    logic [15:0] cur_fmt;
    logic [15:0] cur_chans;
    logic [31:0] cur_rate;
    logic [15:0] cur_bits;
    logic [31:0] cur_remain;
    err_t        cur_err;

    logic        fail_c;
    err_t        fail_code_c;
    kind_t       kind_c;
    logic [7:0]  pbyte_c;
    logic        last_c;
    logic        accepted_c;
    logic [31:0] frames_c;

    logic        out_valid_reg;
    kind_t       kind_reg;
    err_t        out_err_reg;
    logic [7:0]  pbyte_reg;
    logic        last_reg;
    logic [1:0]  ch_count_reg;
    logic [4:0]  sbits_reg;
    logic [31:0] srate_reg;
    logic [31:0] dsize_reg;
    logic [31:0] frames_reg;

    logic        advance;
    logic        step;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign step        = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg    <= in_ch.data_byte;
            in_restart_reg <= in_ch.restart;
        end
    end

    // parse step
    always_comb
    begin
        cur_phase  = in_restart_reg ? PH_RIFF  : phase_reg;
        cur_idx    = in_restart_reg ? '0       : idx_reg;
        cur_skip   = in_restart_reg ? '0       : skip_reg;
        cur_tag    = in_restart_reg ? '0       : tag_reg;
        cur_len    = in_restart_reg ? '0       : len_reg;
        cur_fmt    = in_restart_reg ? '0       : fmt_reg;
        cur_chans  = in_restart_reg ? '0       : chans_reg;
        cur_rate   = in_restart_reg ? '0       : rate_reg;
        cur_bits   = in_restart_reg ? '0       : bits_reg;
        cur_remain = in_restart_reg ? '0       : remain_reg;
        cur_err    = in_restart_reg ? ERR_NONE : err_reg;

        phase_next  = cur_phase;
        idx_next    = cur_idx;
        skip_next   = cur_skip;
        tag_next    = cur_tag;
        len_next    = cur_len;
        fmt_next    = cur_fmt;
        chans_next  = cur_chans;
        rate_next   = cur_rate;
        bits_next   = cur_bits;
        remain_next = cur_remain;
        err_next    = cur_err;

        fail_c      = 1'b0;
        fail_code_c = ERR_NONE;
        kind_c      = KIND_HEADER;
        pbyte_c     = '0;
        last_c      = 1'b0;

        unique case (cur_phase)
            PH_RIFF:
            begin
                tag_next = {in_byte_reg, cur_tag[31:8]};
                if (cur_idx == RIFF_LAST_IDX && tag_next != TAG_RIFF)
                begin
                    fail_c      = 1'b1;
                    fail_code_c = ERR_RIFF_WAVE;
                end
                else if (cur_idx >= WAVE_LAST_IDX)
                begin
                    idx_next = '0;
                    if (tag_next != TAG_WAVE)
                    begin
                        fail_c      = 1'b1;
                        fail_code_c = ERR_RIFF_WAVE;
                    end
                    else
                    begin
                        phase_next = PH_HDR_FMT;
                    end
                end
                else
                begin
                    idx_next = cur_idx + 5'd1;
                end
            end
            PH_HDR_FMT, PH_HDR_DATA:
            begin
                if (cur_idx < TAG_BYTES)
                begin
                    tag_next = {in_byte_reg, cur_tag[31:8]};
                end
                else
                begin
                    len_next = {in_byte_reg, cur_len[31:8]};
                end
                if (cur_idx < HDR_LAST_IDX)
                begin
                    idx_next = cur_idx + 5'd1;
                end
                else
                begin
                    idx_next = '0;
                    if (tag_next == TAG_JUNK || tag_next == TAG_LIST)
                    begin
                        skip_next = len_next;
                        if (len_next != '0)
                        begin
                            phase_next = (cur_phase == PH_HDR_DATA) ? PH_SKIP_DATA
                                                                    : PH_SKIP_FMT;
                        end
                    end
                    else if (cur_phase == PH_HDR_FMT)
                    begin
                        if (tag_next == TAG_FMT)
                        begin
                            phase_next = PH_FMT_BODY;
                        end
                        else
                        begin
                            fail_c      = 1'b1;
                            fail_code_c = ERR_NO_FMT;
                        end
                    end
                    else if (tag_next != TAG_DATA)
                    begin
                        fail_c      = 1'b1;
                        fail_code_c = ERR_NO_DATA;
                    end
                    else if (cur_bits != BITS_8 && cur_bits != BITS_16)
                    begin
                        fail_c      = 1'b1;
                        fail_code_c = ERR_BITS;
                    end
                    else if (cur_chans != CHANNELS_1 && cur_chans != CHANNELS_2)
                    begin
                        fail_c      = 1'b1;
                        fail_code_c = ERR_CHANNELS;
                    end
                    else
                    begin
                        remain_next = len_next;
                        phase_next  = (len_next != '0) ? PH_PAYLOAD : PH_DONE;
                        kind_c      = KIND_ACCEPT;
                    end
                end
            end
            PH_SKIP_FMT, PH_SKIP_DATA:
            begin
                kind_c    = KIND_IGNORED;
                skip_next = cur_skip - 32'd1;
                if (skip_next == '0)
                begin
                    idx_next   = '0;
                    phase_next = (cur_phase == PH_SKIP_FMT) ? PH_HDR_FMT : PH_HDR_DATA;
                end
            end
            PH_FMT_BODY:
            begin
                if (cur_idx < FMT_CH_IDX)
                begin
                    fmt_next = {in_byte_reg, cur_fmt[15:8]};
                end
                else if (cur_idx < FMT_RATE_IDX)
                begin
                    chans_next = {in_byte_reg, cur_chans[15:8]};
                end
                else if (cur_idx < FMT_RATE_END)
                begin
                    rate_next = {in_byte_reg, cur_rate[31:8]};
                end
                else if (cur_idx >= FMT_BITS_IDX)
                begin
                    bits_next = {in_byte_reg, cur_bits[15:8]};
                end
                if (cur_idx >= FMT_LAST_IDX)
                begin
                    idx_next = '0;
                    if (fmt_next != PCM_TAG)
                    begin
                        fail_c      = 1'b1;
                        fail_code_c = ERR_NOT_PCM;
                    end
                    else if (cur_len != FMT_SIZE)
                    begin
                        fail_c      = 1'b1;
                        fail_code_c = ERR_FMT_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_HDR_DATA;
                    end
                end
                else
                begin
                    idx_next = cur_idx + 5'd1;
                end
            end
            PH_PAYLOAD:
            begin
                kind_c      = KIND_PAYLOAD;
                pbyte_c     = in_byte_reg;
                remain_next = cur_remain - 32'd1;
                if (remain_next == '0)
                begin
                    last_c     = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_ERROR:
            begin
                kind_c = KIND_ERROR;
            end
            default:
            begin
                kind_c = KIND_IGNORED;
            end
        endcase

        if (fail_c)
        begin
            phase_next = PH_ERROR;
            kind_c     = KIND_ERROR;
            if (cur_err == ERR_NONE)
            begin
                err_next = fail_code_c;
            end
        end

        accepted_c = (phase_next == PH_PAYLOAD) || (phase_next == PH_DONE);

        // bytes per frame is 1, 2 or 4
        case ({bits_next == BITS_16, chans_next == CHANNELS_2}) inside
            2'b11:        frames_c = {2'b00, len_next[31:2]};
            2'b10, 2'b01: frames_c = {1'b0, len_next[31:1]};
            default:      frames_c = len_next;
        endcase
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            idx_reg    <= '0;
            skip_reg   <= '0;
            tag_reg    <= '0;
            len_reg    <= '0;
            fmt_reg    <= '0;
            chans_reg  <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            remain_reg <= '0;
            err_reg    <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            skip_reg   <= skip_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            fmt_reg    <= fmt_next;
            chans_reg  <= chans_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            kind_reg     <= kind_c;
            out_err_reg  <= err_next;
            pbyte_reg    <= pbyte_c;
            last_reg     <= last_c;
            ch_count_reg <= accepted_c ? chans_next[1:0] : 2'd0;
            sbits_reg    <= accepted_c ? bits_next[4:0]  : 5'd0;
            srate_reg    <= accepted_c ? rate_next       : 32'd0;
            dsize_reg    <= accepted_c ? len_next        : 32'd0;
            frames_reg   <= accepted_c ? frames_c        : 32'd0;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.kind          = kind_reg;
    assign out_ch.error_code    = out_err_reg;
    assign out_ch.payload_byte  = pbyte_reg;
    assign out_ch.last_payload  = last_reg;
    assign out_ch.channel_count = ch_count_reg;
    assign out_ch.sample_bits   = sbits_reg;
    assign out_ch.sample_rate   = srate_reg;
    assign out_ch.data_size     = dsize_reg;
    assign out_ch.frame_count   = frames_reg;

endmodule

`default_nettype wire

### tb/sv/wav_header_parser_core_tb.sv
// wav_header_parser_core_tb: self-checking testbench for the byte-serial wav header parser
// builds directed wav byte streams, models the parser per byte and checks results
// depends on wavhp_pkg, wavhp_in_if, wavhp_out_if and wav_header_parser_core
`timescale 1ns / 1ps

module wav_header_parser_core_tb;
    import wavhp_pkg::*;

    localparam int CYCLE_LIMIT = 20000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        kind_t       kind;
        err_t        err;
        logic [7:0]  pay;
        logic        last;
        logic [1:0]  chans;
        logic [4:0]  smp_bits;
        logic [31:0] rate;
        logic [31:0] dsize;
        logic [31:0] frames;
    } wav_result_t;

    logic clk;
    logic rst_n;

    wavhp_in_if  in_ch ();
    wavhp_out_if out_ch ();

    wav_header_parser_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // parser state mirror
    phase_t      stage;
    logic [4:0]  idx;
    logic [31:0] skip_cnt;
    logic [31:0] tag_shift;
    logic [31:0] len_shift;
    logic [15:0] fmt_code;
    logic [15:0] chan_field;
    logic [31:0] rate_field;
    logic [15:0] bits_field;
    logic [31:0] pay_cnt;
    err_t        first_err;

    wav_result_t parse_results_q[$];
    logic [7:0]  file_q[$];

    int          cycle_cnt;
    int          mismatch_cnt;
    int          sent_cnt;
    int          files_sent;
    int          kind_cnt[5];
    logic [7:0]  err_seen;
    bit          idle_on;
    int          hold_cycles;
    int          stall_left;
    wav_result_t got;
    wav_result_t want;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt > CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words pending", cycle_cnt,
                 parse_results_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- parser model

    function automatic void clear_parser();
        stage      = PH_RIFF;
        idx        = '0;
        skip_cnt   = '0;
        tag_shift  = '0;
        len_shift  = '0;
        fmt_code   = '0;
        chan_field = '0;
        rate_field = '0;
        bits_field = '0;
        pay_cnt    = '0;
        first_err  = ERR_NONE;
    endfunction

    function automatic void raise_error(err_t code);
        if (first_err == ERR_NONE)
            first_err = code;
        stage = PH_ERROR;
    endfunction

    // one byte of an 8-byte chunk header, returns 1 when the data header is accepted
    function automatic bit take_chunk_hdr(logic [7:0] b, bit pre_data);
        if (idx < TAG_BYTES)
            tag_shift = {b, tag_shift[31:8]};
        else
            len_shift = {b, len_shift[31:8]};
        if (idx < HDR_LAST_IDX)
        begin
            idx = idx + 5'd1;
            return 1'b0;
        end
        idx = '0;
        if (tag_shift == TAG_JUNK || tag_shift == TAG_LIST)
        begin
            skip_cnt = len_shift;
            if (len_shift != 0)
                stage = pre_data ? PH_SKIP_DATA : PH_SKIP_FMT;
            return 1'b0;
        end
        if (!pre_data)
        begin
            if (tag_shift == TAG_FMT)
                stage = PH_FMT_BODY;
            else
                raise_error(ERR_NO_FMT);
            return 1'b0;
        end
        if (tag_shift != TAG_DATA)
        begin
            raise_error(ERR_NO_DATA);
            return 1'b0;
        end
        if (bits_field != BITS_8 && bits_field != BITS_16)
        begin
            raise_error(ERR_BITS);
            return 1'b0;
        end
        if (chan_field != CHANNELS_1 && chan_field != CHANNELS_2)
        begin
            raise_error(ERR_CHANNELS);
            return 1'b0;
        end
        pay_cnt = len_shift;
        stage = (len_shift != 0) ? PH_PAYLOAD : PH_DONE;
        return 1'b1;
    endfunction

    function automatic wav_result_t parse_file_byte(logic [7:0] b, logic rs);
        wav_result_t r;
        int          shift;
        r = '0;
        if (rs)
            clear_parser();
        r.kind = KIND_HEADER;
        case (stage)
            PH_RIFF:
            begin
                tag_shift = {b, tag_shift[31:8]};
                if (idx == RIFF_LAST_IDX && tag_shift != TAG_RIFF)
                    raise_error(ERR_RIFF_WAVE);
                else if (idx >= WAVE_LAST_IDX)
                begin
                    idx = '0;
                    if (tag_shift != TAG_WAVE)
                        raise_error(ERR_RIFF_WAVE);
                    else
                        stage = PH_HDR_FMT;
                end
                else
                    idx = idx + 5'd1;
            end
            PH_HDR_FMT:
                void'(take_chunk_hdr(b, 1'b0));
            PH_HDR_DATA:
                if (take_chunk_hdr(b, 1'b1))
                    r.kind = KIND_ACCEPT;
            PH_SKIP_FMT, PH_SKIP_DATA:
            begin
                r.kind = KIND_IGNORED;
                skip_cnt = skip_cnt - 32'd1;
                if (skip_cnt == 0)
                begin
                    idx = '0;
                    stage = (stage == PH_SKIP_FMT) ? PH_HDR_FMT : PH_HDR_DATA;
                end
            end
            PH_FMT_BODY:
            begin
                if (idx < FMT_CH_IDX)
                    fmt_code = {b, fmt_code[15:8]};
                else if (idx < FMT_RATE_IDX)
                    chan_field = {b, chan_field[15:8]};
                else if (idx < FMT_RATE_END)
                    rate_field = {b, rate_field[31:8]};
                else if (idx >= FMT_BITS_IDX)
                    bits_field = {b, bits_field[15:8]};
                if (idx >= FMT_LAST_IDX)
                begin
                    idx = '0;
                    if (fmt_code != PCM_TAG)
                        raise_error(ERR_NOT_PCM);
                    else if (len_shift != FMT_SIZE)
                        raise_error(ERR_FMT_SIZE);
                    else
                        stage = PH_HDR_DATA;
                end
                else
                    idx = idx + 5'd1;
            end
            PH_PAYLOAD:
            begin
                r.kind = KIND_PAYLOAD;
                r.pay = b;
                pay_cnt = pay_cnt - 32'd1;
                if (pay_cnt == 0)
                begin
                    r.last = 1'b1;
                    stage = PH_DONE;
                end
            end
            PH_ERROR:
                r.kind = KIND_ERROR;
            default:
                r.kind = KIND_IGNORED;
        endcase
        if (stage == PH_ERROR)
            r.kind = KIND_ERROR;
        r.err = first_err;
        if (stage == PH_PAYLOAD || stage == PH_DONE)
        begin
            shift = int'(bits_field == BITS_16) + int'(chan_field == CHANNELS_2);
            r.chans    = chan_field[1:0];
            r.smp_bits = bits_field[4:0];
            r.rate     = rate_field;
            r.dsize    = len_shift;
            r.frames   = len_shift >> shift;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- file builders

    function automatic void put_u16(logic [15:0] v);
        file_q.push_back(v[7:0]);
        file_q.push_back(v[15:8]);
    endfunction

    function automatic void put_u32(logic [31:0] v);
        put_u16(v[15:0]);
        put_u16(v[31:16]);
    endfunction

    function automatic void put_noise(int n);
        repeat (n) file_q.push_back(8'($urandom));
    endfunction

    function automatic void put_riff(logic [31:0] riff_tag, logic [31:0] wave_tag);
        put_u32(riff_tag);
        put_u32($urandom);
        put_u32(wave_tag);
    endfunction

    function automatic void put_skip(logic [31:0] tag, logic [31:0] len, int body);
        put_u32(tag);
        put_u32(len);
        put_noise(body);
    endfunction

    function automatic void put_fmt(logic [31:0] fsize, logic [15:0] code, logic [15:0] ch,
                                    logic [31:0] rate, logic [15:0] nbits);
        put_u32(TAG_FMT);
        put_u32(fsize);
        put_u16(code);
        put_u16(ch);
        put_u32(rate);
        put_u32($urandom);
        put_u16(16'($urandom));
        put_u16(nbits);
    endfunction

    function automatic void put_pcm_header(logic [15:0] ch, logic [15:0] nbits,
                                           logic [31:0] rate, logic [31:0] len);
        put_riff(TAG_RIFF, TAG_WAVE);
        put_fmt(FMT_SIZE, PCM_TAG, ch, rate, nbits);
        put_skip(TAG_DATA, len, 0);
    endfunction

    function automatic void put_fmt_case(logic [31:0] fsize, logic [15:0] code,
                                         logic [15:0] ch, logic [15:0] nbits);
        put_riff(TAG_RIFF, TAG_WAVE);
        put_fmt(fsize, code, ch, $urandom, nbits);
        put_skip(TAG_DATA, 2, 1);
    endfunction

    // ---------------------------------------------------------------- channel drivers

    task automatic send_byte(input logic [7:0] b, input logic rs);
        wav_result_t r;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.restart   <= rs;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        r = parse_file_byte(b, rs);
        parse_results_q.push_back(r);
        kind_cnt[r.kind]++;
        err_seen[r.err] = 1'b1;
        sent_cnt++;
    endtask

    task automatic send_file(input logic first_restart);
        foreach (file_q[i])
            send_byte(file_q[i], (i == 0) ? first_restart : 1'b0);
        file_q.delete();
        files_sent++;
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (parse_results_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    function automatic void show_word(string tag, wav_result_t w);
        $display("  %s kind=%0d err=%0d byte=%02h last=%0d ch=%0d bits=%0d",
                 tag, w.kind, w.err, w.pay, w.last, w.chans, w.smp_bits);
        $display("      rate=%08h size=%08h frames=%08h", w.rate, w.dsize, w.frames);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.kind     = out_ch.kind;
            got.err      = out_ch.error_code;
            got.pay      = out_ch.payload_byte;
            got.last     = out_ch.last_payload;
            got.chans    = out_ch.channel_count;
            got.smp_bits = out_ch.sample_bits;
            got.rate     = out_ch.sample_rate;
            got.dsize    = out_ch.data_size;
            got.frames   = out_ch.frame_count;
            if (parse_results_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOW_LIMIT)
                begin
                    $display("unexpected result word at cycle %0d", cycle_cnt);
                    show_word("got", got);
                end
            end
            else
            begin
                want = parse_results_q.pop_front();
                if (got !== want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOW_LIMIT)
                    begin
                        $display("mismatch %0d at cycle %0d", mismatch_cnt, cycle_cnt);
                        show_word("exp", want);
                        show_word("got", got);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_chunk_skipping();
        // first file after reset without restart
        put_riff(TAG_RIFF, TAG_WAVE);
        put_skip(TAG_JUNK, 0, 0);
        put_skip(TAG_LIST, 3, 3);
        put_fmt(FMT_SIZE, PCM_TAG, CHANNELS_1, 32'h0000_0000, BITS_8);
        put_skip(TAG_LIST, 0, 0);
        put_skip(TAG_JUNK, 2, 2);
        put_skip(TAG_DATA, 3, 0);
        file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h55);
        put_noise(1);
        send_file(1'b0);
        wait_results_done();
    endtask

    task automatic test_header_errors();
        put_u32(32'h5846_4952);
        put_noise(2);
        send_file(1'b1);
        put_riff(TAG_RIFF, TAG_WAVE ^ 32'h8000_0000);
        put_noise(1);
        send_file(1'b1);
        put_riff(TAG_RIFF, TAG_WAVE);
        put_skip(TAG_DATA, 8, 1);
        send_file(1'b1);
        // format tag wins over a bad size
        put_fmt_case(32'hFFFF_FFFF, 16'hFFFE, CHANNELS_2, BITS_16);
        send_file(1'b1);
        put_fmt_case(32'd18, PCM_TAG, CHANNELS_1, BITS_8);
        send_file(1'b1);
        put_riff(TAG_RIFF, TAG_WAVE);
        put_fmt(FMT_SIZE, PCM_TAG, CHANNELS_1, $urandom, BITS_8);
        put_skip(32'h7463_6166, 4, 1);
        send_file(1'b1);
        // bits checked before channels
        put_fmt_case(FMT_SIZE, PCM_TAG, 16'd3, 16'd24);
        send_file(1'b1);
        put_fmt_case(FMT_SIZE, PCM_TAG, 16'd0, BITS_16);
        send_file(1'b1);
        wait_results_done();
    endtask

    task automatic test_size_extremes();
        put_pcm_header(CHANNELS_1, BITS_16, $urandom, 0);
        put_noise(2);
        send_file(1'b1);
        // huge data and skip sizes, cut short by the next restart
        put_pcm_header(CHANNELS_2, BITS_8, $urandom, 32'hFFFF_FFFF);
        put_noise(3);
        send_file(1'b1);
        put_riff(TAG_RIFF, TAG_WAVE);
        put_skip(TAG_JUNK, 32'hFFFF_FFFF, 3);
        send_file(1'b1);
        wait_results_done();
    endtask

    task automatic test_result_stall();
        hold_cycles = 120;
        put_pcm_header(CHANNELS_2, BITS_16, 32'hFFFF_FFFF, 6);
        put_noise(6);
        send_file(1'b1);
        wait_results_done();
    endtask

    initial
    begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.restart   = 1'b0;
        rst_n           = 1'b0;
        idle_on         = 1'b1;
        hold_cycles     = 0;
        cycle_cnt       = 0;
        mismatch_cnt    = 0;
        sent_cnt        = 0;
        files_sent      = 0;
        err_seen        = '0;
        foreach (kind_cnt[k])
            kind_cnt[k] = 0;
        clear_parser();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_chunk_skipping();
        test_header_errors();
        idle_on = 1'b0;
        test_size_extremes();
        test_result_stall();

        wait_results_done();
        repeat (10) @(posedge clk);
        $display("covered %0d files, %0d bytes: %0d header, %0d accepted, %0d payload,",
                 files_sent, sent_cnt, kind_cnt[KIND_HEADER], kind_cnt[KIND_ACCEPT],
                 kind_cnt[KIND_PAYLOAD]);
        $display("  %0d error, %0d ignored; error codes seen %08b, %0d mismatches, %0d cycles",
                 kind_cnt[KIND_ERROR], kind_cnt[KIND_IGNORED], err_seen, mismatch_cnt,
                 cycle_cnt);
        if (mismatch_cnt == 0 && parse_results_q.size() == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d result words never arrived", parse_results_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/wavhp_pkg.sv
rtl/wavhp_in_if.sv
rtl/wavhp_out_if.sv
rtl/wav_header_parser_core.sv
tb/sv/wav_header_parser_core_tb.sv
